FILE: src/bpv_pkg.sv
// ----------------------------------------------------------------------------
// bpv_pkg
// Shared constants, register indexes and stage-enable type for the brick
// pattern value pipeline.
// ----------------------------------------------------------------------------
package bpv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SCALED_W   = 2 * FRAC_BITS + 1;
    localparam int NUM_STAGES = 6;

    localparam int Q16_W   = 16;
    localparam int UNIT_W  = Q16_W + 1;
    localparam int RAMP_W  = Q16_W + 32;
    localparam int SQ_W    = 2 * UNIT_W - 1;
    localparam int COEF_W  = UNIT_W + 1;
    localparam int HPROD_W = SQ_W + COEF_W;
    localparam int MXY_W   = 2 * UNIT_W;
    localparam int MALL_W  = MXY_W + UNIT_W;
    localparam int PROD_W  = MALL_W - 32;

    localparam logic [UNIT_W-1:0] Q16_ONE    = UNIT_W'(65536);
    localparam logic [COEF_W-1:0] HERM_THREE = COEF_W'(3 * 65536);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TOTAL_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INV_TOTAL_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MORTAR_FRAC_W     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MORTAR_FRAC_H     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INV_MORTAR_FRAC_W = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_INV_MORTAR_FRAC_H = CFG_IDX_W'(5);

    localparam logic [31:0] RST_INV_TOTAL_WIDTH   = 32'd65536;
    localparam logic [31:0] RST_INV_TOTAL_HEIGHT  = 32'd131072;
    localparam logic [15:0] RST_MORTAR_FRAC_W     = 16'd3277;
    localparam logic [15:0] RST_MORTAR_FRAC_H     = 16'd6554;
    localparam logic [31:0] RST_INV_MORTAR_FRAC_W = 32'd1310720;
    localparam logic [31:0] RST_INV_MORTAR_FRAC_H = 32'd655360;

    typedef struct packed {
        logic scale;
        logic ramp;
        logic square;
        logic herm;
        logic mult;
        logic out;
    } stage_en_t;

endpackage

FILE: src/bpv_scale.sv
// ----------------------------------------------------------------------------
// bpv_scale
// Scale one coordinate by its reciprocal; keep the low product bits that
// carry the fraction and the parity of the integer part.
// ----------------------------------------------------------------------------
module bpv_scale
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [31:0]                coord,
    input  logic        [31:0]                recip,
    output logic        [bpv_pkg::SCALED_W-1:0] prod
);

    logic [bpv_pkg::SCALED_W-1:0] coord_ext;
    logic [bpv_pkg::SCALED_W-1:0] recip_ext;
    logic [bpv_pkg::SCALED_W-1:0] prod_next;
    logic [bpv_pkg::SCALED_W-1:0] prod_reg;

    assign coord_ext = bpv_pkg::SCALED_W'(coord);
    assign recip_ext = bpv_pkg::SCALED_W'(recip);
    assign prod_next = coord_ext * recip_ext;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: src/bpv_axis.sv
// ----------------------------------------------------------------------------
// bpv_axis
// Per-axis weight terms: fraction, rising and falling ramps, clamp, and the
// Hermite smoothstep, over three register stages.
// ----------------------------------------------------------------------------
module bpv_axis
(
    input  logic                               clk,
    input  bpv_pkg::stage_en_t                 en,
    input  logic [bpv_pkg::SCALED_W-1:0]       prod,
    input  logic                               add_half,
    input  logic [15:0]                        mfrac,
    input  logic [31:0]                        inv_mfrac,
    output logic [bpv_pkg::UNIT_W-1:0]         h_up,
    output logic [bpv_pkg::UNIT_W-1:0]         h_down
);

    localparam int FB = bpv_pkg::FRAC_BITS;

    logic [bpv_pkg::Q16_W-1:0]  frac;
    logic [bpv_pkg::UNIT_W-1:0] edge_pos;
    logic                       down_en_next;
    logic [bpv_pkg::UNIT_W-1:0] down_diff;
    logic [bpv_pkg::Q16_W-1:0]  down_num;
    logic [bpv_pkg::RAMP_W-1:0] up_ramp_next;
    logic [bpv_pkg::RAMP_W-1:0] down_ramp_next;

    logic [bpv_pkg::RAMP_W-1:0] up_ramp_reg;
    logic [bpv_pkg::RAMP_W-1:0] down_ramp_reg;
    logic                       down_en_reg;

    logic [bpv_pkg::UNIT_W-1:0] t_up;
    logic [bpv_pkg::UNIT_W-1:0] t_down;
    logic [bpv_pkg::SQ_W-1:0]   sq_up_next;
    logic [bpv_pkg::SQ_W-1:0]   sq_down_next;

    logic [bpv_pkg::UNIT_W-1:0] t_up_reg;
    logic [bpv_pkg::UNIT_W-1:0] t_down_reg;
    logic [bpv_pkg::SQ_W-1:0]   sq_up_reg;
    logic [bpv_pkg::SQ_W-1:0]   sq_down_reg;
    logic                       down_en_sq_reg;

    logic [bpv_pkg::COEF_W-1:0]  coef_up;
    logic [bpv_pkg::COEF_W-1:0]  coef_down;
    logic [bpv_pkg::HPROD_W-1:0] hp_up;
    logic [bpv_pkg::HPROD_W-1:0] hp_down;
    logic [bpv_pkg::UNIT_W-1:0]  h_up_next;
    logic [bpv_pkg::UNIT_W-1:0]  h_down_next;
    logic [bpv_pkg::UNIT_W-1:0]  h_up_reg;
    logic [bpv_pkg::UNIT_W-1:0]  h_down_reg;

    // fraction, with the half-brick offset folded into its top bit
    assign frac = {prod[2*FB-1] ^ add_half, prod[2*FB-2 -: bpv_pkg::Q16_W-1]};

    assign edge_pos       = bpv_pkg::Q16_ONE - {1'b0, mfrac};
    assign down_en_next   = {1'b0, frac} > edge_pos;
    assign down_diff      = {1'b0, frac} - edge_pos;
    assign down_num       = down_diff[bpv_pkg::Q16_W-1:0];
    assign up_ramp_next   = bpv_pkg::RAMP_W'(frac) * bpv_pkg::RAMP_W'(inv_mfrac);
    assign down_ramp_next = bpv_pkg::RAMP_W'(down_num) * bpv_pkg::RAMP_W'(inv_mfrac);

    always_ff @(posedge clk)
    begin
        if (en.ramp)
        begin
            up_ramp_reg   <= up_ramp_next;
            down_ramp_reg <= down_ramp_next;
            down_en_reg   <= down_en_next;
        end
    end

    // saturate ramps to one
    always_comb
    begin
        if (up_ramp_reg[bpv_pkg::RAMP_W-1:16] > 32'(bpv_pkg::Q16_ONE))
        begin
            t_up = bpv_pkg::Q16_ONE;
        end
        else
        begin
            t_up = up_ramp_reg[16 +: bpv_pkg::UNIT_W];
        end
        if (down_ramp_reg[bpv_pkg::RAMP_W-1:16] > 32'(bpv_pkg::Q16_ONE))
        begin
            t_down = bpv_pkg::Q16_ONE;
        end
        else
        begin
            t_down = down_ramp_reg[16 +: bpv_pkg::UNIT_W];
        end
    end

    assign sq_up_next   = bpv_pkg::SQ_W'(t_up) * bpv_pkg::SQ_W'(t_up);
    assign sq_down_next = bpv_pkg::SQ_W'(t_down) * bpv_pkg::SQ_W'(t_down);

    always_ff @(posedge clk)
    begin
        if (en.square)
        begin
            t_up_reg       <= t_up;
            t_down_reg     <= t_down;
            sq_up_reg      <= sq_up_next;
            sq_down_reg    <= sq_down_next;
            down_en_sq_reg <= down_en_reg;
        end
    end

    assign coef_up     = bpv_pkg::HERM_THREE - {t_up_reg, 1'b0};
    assign coef_down   = bpv_pkg::HERM_THREE - {t_down_reg, 1'b0};
    assign hp_up       = bpv_pkg::HPROD_W'(sq_up_reg) * bpv_pkg::HPROD_W'(coef_up);
    assign hp_down     = bpv_pkg::HPROD_W'(sq_down_reg) * bpv_pkg::HPROD_W'(coef_down);
    assign h_up_next   = hp_up[32 +: bpv_pkg::UNIT_W];
    assign h_down_next = down_en_sq_reg ? hp_down[32 +: bpv_pkg::UNIT_W] : '0;

    always_ff @(posedge clk)
    begin
        if (en.herm)
        begin
            h_up_reg   <= h_up_next;
            h_down_reg <= h_down_next;
        end
    end

    assign h_up   = h_up_reg;
    assign h_down = h_down_reg;

endmodule

FILE: src/bpv_combine.sv
// ----------------------------------------------------------------------------
// bpv_combine
// Form the three signed axis weights, multiply their magnitudes over two
// stages and clamp the product to the unit range.
// ----------------------------------------------------------------------------
module bpv_combine
(
    input  logic                        clk,
    input  bpv_pkg::stage_en_t          en,
    input  logic [bpv_pkg::UNIT_W-1:0]  x_up,
    input  logic [bpv_pkg::UNIT_W-1:0]  x_down,
    input  logic [bpv_pkg::UNIT_W-1:0]  y_up,
    input  logic [bpv_pkg::UNIT_W-1:0]  y_down,
    input  logic [bpv_pkg::UNIT_W-1:0]  z_up,
    input  logic [bpv_pkg::UNIT_W-1:0]  z_down,
    output logic [bpv_pkg::UNIT_W-1:0]  value
);

    logic                        x_neg;
    logic                        y_neg;
    logic                        z_neg;
    logic [bpv_pkg::UNIT_W-1:0]  x_mag;
    logic [bpv_pkg::UNIT_W-1:0]  y_mag;
    logic [bpv_pkg::UNIT_W-1:0]  z_mag;
    logic [bpv_pkg::MXY_W-1:0]   mxy_next;

    logic [bpv_pkg::MXY_W-1:0]   mxy_reg;
    logic [bpv_pkg::UNIT_W-1:0]  z_mag_reg;
    logic                        neg_reg;

    logic [bpv_pkg::MALL_W-1:0]  mall;
    logic [bpv_pkg::PROD_W-1:0]  p;
    logic [bpv_pkg::UNIT_W-1:0]  value_next;
    logic [bpv_pkg::UNIT_W-1:0]  value_reg;

    assign x_neg = x_down > x_up;
    assign y_neg = y_down > y_up;
    assign z_neg = z_down > z_up;
    assign x_mag = x_neg ? (x_down - x_up) : (x_up - x_down);
    assign y_mag = y_neg ? (y_down - y_up) : (y_up - y_down);
    assign z_mag = z_neg ? (z_down - z_up) : (z_up - z_down);

    assign mxy_next = bpv_pkg::MXY_W'(x_mag) * bpv_pkg::MXY_W'(y_mag);

    always_ff @(posedge clk)
    begin
        if (en.mult)
        begin
            mxy_reg   <= mxy_next;
            z_mag_reg <= z_mag;
            neg_reg   <= x_neg ^ y_neg ^ z_neg;
        end
    end

    assign mall = bpv_pkg::MALL_W'(mxy_reg) * bpv_pkg::MALL_W'(z_mag_reg);
    assign p    = mall[bpv_pkg::MALL_W-1:32];

    always_comb
    begin
        if (neg_reg || p == '0)
        begin
            value_next = '0;
        end
        else if (p > bpv_pkg::PROD_W'(bpv_pkg::Q16_ONE))
        begin
            value_next = bpv_pkg::Q16_ONE;
        end
        else
        begin
            value_next = p[bpv_pkg::UNIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.out)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: src/brick_pattern_value_unit.sv
// ----------------------------------------------------------------------------
// brick_pattern_value_unit
// Procedural brick texture weight for a stream of 3D points. Each request
// carries a signed Q16.16 point and returns one unsigned Q1.16 weight
// (65536 is full brick, 0 is mortar). The datapath is a six-stage multiplier
// pipeline (scale, ramp, square, smoothstep, two-step triple product), and
// one request is taken every cycle unless output back-pressure stalls the
// pipeline. Each stage holds its item while the stage ahead cannot advance,
// so bubbles close up under output back-pressure. Configuration writes are
// always taken (cfg_ready is high) and act at once; write them only while
// no request is in flight. Indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module brick_pattern_value_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [31:0]                 coord_x,
    input  logic signed [31:0]                 coord_y,
    input  logic signed [31:0]                 coord_z,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bpv_pkg::UNIT_W-1:0]         pattern_value
);

    logic [31:0] inv_total_width_reg;
    logic [31:0] inv_total_height_reg;
    logic [15:0] mortar_frac_w_reg;
    logic [15:0] mortar_frac_h_reg;
    logic [31:0] inv_mortar_frac_w_reg;
    logic [31:0] inv_mortar_frac_h_reg;

    logic [bpv_pkg::NUM_STAGES-1:0] valid_reg;
    logic [bpv_pkg::NUM_STAGES-1:0] valid_next;
    logic [bpv_pkg::NUM_STAGES-1:0] adv;
    bpv_pkg::stage_en_t             en;

    logic [bpv_pkg::SCALED_W-1:0] sx;
    logic [bpv_pkg::SCALED_W-1:0] sy;
    logic [bpv_pkg::SCALED_W-1:0] sz;
    logic                         even_row;

    logic [bpv_pkg::UNIT_W-1:0] x_up;
    logic [bpv_pkg::UNIT_W-1:0] x_down;
    logic [bpv_pkg::UNIT_W-1:0] y_up;
    logic [bpv_pkg::UNIT_W-1:0] y_down;
    logic [bpv_pkg::UNIT_W-1:0] z_up;
    logic [bpv_pkg::UNIT_W-1:0] z_down;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_total_width_reg   <= bpv_pkg::RST_INV_TOTAL_WIDTH;
            inv_total_height_reg  <= bpv_pkg::RST_INV_TOTAL_HEIGHT;
            mortar_frac_w_reg     <= bpv_pkg::RST_MORTAR_FRAC_W;
            mortar_frac_h_reg     <= bpv_pkg::RST_MORTAR_FRAC_H;
            inv_mortar_frac_w_reg <= bpv_pkg::RST_INV_MORTAR_FRAC_W;
            inv_mortar_frac_h_reg <= bpv_pkg::RST_INV_MORTAR_FRAC_H;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpv_pkg::REG_INV_TOTAL_WIDTH:   inv_total_width_reg   <= cfg_data;
                bpv_pkg::REG_INV_TOTAL_HEIGHT:  inv_total_height_reg  <= cfg_data;
                bpv_pkg::REG_MORTAR_FRAC_W:     mortar_frac_w_reg     <= cfg_data[15:0];
                bpv_pkg::REG_MORTAR_FRAC_H:     mortar_frac_h_reg     <= cfg_data[15:0];
                bpv_pkg::REG_INV_MORTAR_FRAC_W: inv_mortar_frac_w_reg <= cfg_data;
                bpv_pkg::REG_INV_MORTAR_FRAC_H: inv_mortar_frac_h_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // advance a stage when it is empty or the stage ahead advances
    always_comb
    begin
        adv[bpv_pkg::NUM_STAGES-1] = !valid_reg[bpv_pkg::NUM_STAGES-1] || out_ready;
        for (int i = bpv_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int i = 1; i < bpv_pkg::NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    assign en.scale  = adv[0];
    assign en.ramp   = adv[1];
    assign en.square = adv[2];
    assign en.herm   = adv[3];
    assign en.mult   = adv[4];
    assign en.out    = adv[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[bpv_pkg::NUM_STAGES-1];

    bpv_scale u_scale_x
    (
        .clk   (clk),
        .en    (en.scale),
        .coord (coord_x),
        .recip (inv_total_width_reg),
        .prod  (sx)
    );

    bpv_scale u_scale_y
    (
        .clk   (clk),
        .en    (en.scale),
        .coord (coord_y),
        .recip (inv_total_height_reg),
        .prod  (sy)
    );

    bpv_scale u_scale_z
    (
        .clk   (clk),
        .en    (en.scale),
        .coord (coord_z),
        .recip (inv_total_width_reg),
        .prod  (sz)
    );

    // offset alternate rows by half a brick
    assign even_row = !sy[2*bpv_pkg::FRAC_BITS];

    bpv_axis u_axis_x
    (
        .clk       (clk),
        .en        (en),
        .prod      (sx),
        .add_half  (even_row),
        .mfrac     (mortar_frac_w_reg),
        .inv_mfrac (inv_mortar_frac_w_reg),
        .h_up      (x_up),
        .h_down    (x_down)
    );

    bpv_axis u_axis_y
    (
        .clk       (clk),
        .en        (en),
        .prod      (sy),
        .add_half  (1'b0),
        .mfrac     (mortar_frac_h_reg),
        .inv_mfrac (inv_mortar_frac_h_reg),
        .h_up      (y_up),
        .h_down    (y_down)
    );

    bpv_axis u_axis_z
    (
        .clk       (clk),
        .en        (en),
        .prod      (sz),
        .add_half  (even_row),
        .mfrac     (mortar_frac_w_reg),
        .inv_mfrac (inv_mortar_frac_w_reg),
        .h_up      (z_up),
        .h_down    (z_down)
    );

    bpv_combine u_combine
    (
        .clk    (clk),
        .en     (en),
        .x_up   (x_up),
        .x_down (x_down),
        .y_up   (y_up),
        .y_down (y_down),
        .z_up   (z_up),
        .z_down (z_down),
        .value  (pattern_value)
    );

endmodule

FILE: test/brick_pattern_value_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brick_pattern_value_unit_tb
// Streams 3D points through the brick weight pipeline under random input
// gaps and output stalls. Each accepted request is scored by a fixed-point
// model of the brick texture (scale, row offset, per-axis smoothstep ramps,
// triple product). Each weight that comes out is compared in order against
// that score. Register settings cover reset values, all-zero, all-one, wide
// mortar and random brick layouts.
// ----------------------------------------------------------------------------
module brick_pattern_value_unit_tb;

    localparam longint unsigned FULL_WEIGHT = 64'd65536;
    localparam int SCALE_FB = 2 * bpv_pkg::FRAC_BITS;
    localparam int DRAIN_CYCLES = 12;
    localparam int RX_HOLD_CYCLES = 200;
    localparam logic [bpv_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = bpv_pkg::CFG_IDX_W'(6);
    localparam logic [bpv_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = bpv_pkg::CFG_IDX_W'(7);

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bpv_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [31:0]                      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic signed [31:0]               coord_x = '0;
    logic signed [31:0]               coord_y = '0;
    logic signed [31:0]               coord_z = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [bpv_pkg::UNIT_W-1:0]       pattern_value;

    logic [31:0] inv_w  = bpv_pkg::RST_INV_TOTAL_WIDTH;
    logic [31:0] inv_h  = bpv_pkg::RST_INV_TOTAL_HEIGHT;
    logic [15:0] mort_w = bpv_pkg::RST_MORTAR_FRAC_W;
    logic [15:0] mort_h = bpv_pkg::RST_MORTAR_FRAC_H;
    logic [31:0] inv_mw = bpv_pkg::RST_INV_MORTAR_FRAC_W;
    logic [31:0] inv_mh = bpv_pkg::RST_INV_MORTAR_FRAC_H;

    logic [bpv_pkg::UNIT_W-1:0] pending_weights [$];
    int  errors = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  rx_hold = 1'b0;
    event rx_hold_ev;

    brick_pattern_value_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pattern_value (pattern_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned smooth_q16(input longint unsigned t);
        return (t * t * (64'd3 * FULL_WEIGHT - 64'd2 * t)) >> 32;
    endfunction

    function automatic longint unsigned ramp_q16(input longint unsigned num,
                                                 input longint unsigned inv);
        longint unsigned t;
        t = (num * inv) >> 16;
        return (t > FULL_WEIGHT) ? FULL_WEIGHT : t;
    endfunction

    function automatic longint axis_weight(input longint unsigned f,
                                           input longint unsigned m,
                                           input longint unsigned inv);
        longint unsigned rim;
        longint unsigned fall;
        rim = FULL_WEIGHT - m;
        fall = 64'd0;
        if (f > rim)
            fall = smooth_q16(ramp_q16(f - rim, inv));
        return longint'(smooth_q16(ramp_q16(f, inv))) - longint'(fall);
    endfunction

    function automatic logic [bpv_pkg::UNIT_W-1:0] brick_weight(input logic [31:0] x,
                                                                input logic [31:0] y,
                                                                input logic [31:0] z);
        logic [63:0]     sx;
        logic [63:0]     sy;
        logic [63:0]     sz;
        longint          w [3];
        longint unsigned mag;
        longint unsigned prod;
        bit              neg;
        sx = {{32{x[31]}}, x} * {32'd0, inv_w};
        sy = {{32{y[31]}}, y} * {32'd0, inv_h};
        sz = {{32{z[31]}}, z} * {32'd0, inv_w};
        // offset every other row by half a brick
        if (!sy[SCALE_FB])
        begin
            sx = sx + (64'd1 << (SCALE_FB - 1));
            sz = sz + (64'd1 << (SCALE_FB - 1));
        end
        w[0] = axis_weight(64'(sx[SCALE_FB-1 -: 16]), 64'(mort_w), 64'(inv_mw));
        w[1] = axis_weight(64'(sy[SCALE_FB-1 -: 16]), 64'(mort_h), 64'(inv_mh));
        w[2] = axis_weight(64'(sz[SCALE_FB-1 -: 16]), 64'(mort_w), 64'(inv_mw));
        mag = 64'd1;
        neg = 1'b0;
        foreach (w[i])
        begin
            if (w[i] < 0)
            begin
                neg = !neg;
                mag = mag * $unsigned(-w[i]);
            end
            else
                mag = mag * $unsigned(w[i]);
        end
        prod = mag >> 32;
        if (neg || prod == 0)
            return '0;
        if (prod > FULL_WEIGHT)
            return bpv_pkg::Q16_ONE;
        return bpv_pkg::UNIT_W'(prod);
    endfunction

    function automatic logic [31:0] mortar_recip(input logic [15:0] m);
        if (m < 16'd2)
            return 32'hFFFF_FFFF;
        return 32'((64'd1 << 32) / m);
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000;
            2: return ($urandom & 32'hFFFF_0000) | $urandom_range(0, 32'h0000_0C00);
            default: return ($urandom & 32'hFFFF_0000)
                            | $urandom_range(32'h0000_F400, 32'h0000_FFFF);
        endcase
    endfunction

    // check each weight that leaves the block, drive output back-pressure
    always @(posedge clk)
    begin : score_weights
        logic [bpv_pkg::UNIT_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_weights.size() == 0)
            begin
                $error("pattern_value: expected none, got %0d", pattern_value);
                errors++;
            end
            else
            begin
                want = pending_weights.pop_front();
                if (pattern_value !== want)
                begin
                    $error("pattern_value: expected %0d, got %0d", want, pattern_value);
                    errors++;
                end
            end
        end
        out_ready <= !rx_hold && (!rx_idle_en || $urandom_range(0, 99) >= 20);
    end

    initial forever
    begin
        @(rx_hold_ev);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while (tx_idle_en && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        do @(posedge clk); while (!in_ready);
        pending_weights.push_back(brick_weight(x, y, z));
    endtask

    task automatic send_random_points(input int count);
        for (int i = 0; i < count; i++)
            send_point(random_coord(), random_coord(), random_coord());
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [bpv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bpv_pkg::REG_INV_TOTAL_WIDTH:   inv_w  = data;
            bpv_pkg::REG_INV_TOTAL_HEIGHT:  inv_h  = data;
            bpv_pkg::REG_MORTAR_FRAC_W:     mort_w = data[15:0];
            bpv_pkg::REG_MORTAR_FRAC_H:     mort_h = data[15:0];
            bpv_pkg::REG_INV_MORTAR_FRAC_W: inv_mw = data;
            bpv_pkg::REG_INV_MORTAR_FRAC_H: inv_mh = data;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_registers(input logic [31:0] iw, input logic [31:0] ih,
                                     input logic [31:0] mw, input logic [31:0] mh,
                                     input logic [31:0] imw, input logic [31:0] imh);
        drain_pipeline();
        cfg_write(bpv_pkg::REG_INV_TOTAL_WIDTH, iw);
        cfg_write(bpv_pkg::REG_INV_TOTAL_HEIGHT, ih);
        cfg_write(bpv_pkg::REG_MORTAR_FRAC_W, mw);
        cfg_write(bpv_pkg::REG_MORTAR_FRAC_H, mh);
        cfg_write(bpv_pkg::REG_INV_MORTAR_FRAC_W, imw);
        cfg_write(bpv_pkg::REG_INV_MORTAR_FRAC_H, imh);
        cfg_close();
    endtask

    task automatic program_reset_values();
        program_registers(bpv_pkg::RST_INV_TOTAL_WIDTH, bpv_pkg::RST_INV_TOTAL_HEIGHT,
                          32'(bpv_pkg::RST_MORTAR_FRAC_W),
                          32'(bpv_pkg::RST_MORTAR_FRAC_H),
                          bpv_pkg::RST_INV_MORTAR_FRAC_W, bpv_pkg::RST_INV_MORTAR_FRAC_H);
    endtask

    task automatic program_brick_layout(input logic [15:0] mw, input logic [15:0] mh);
        program_registers($urandom_range(32'h0000_4000, 32'h0004_0000),
                          $urandom_range(32'h0000_4000, 32'h0004_0000),
                          {16'($urandom), mw},
                          {16'($urandom), mh},
                          mortar_recip(mw), mortar_recip(mh));
    endtask

    task automatic test_reset_extremes();
        logic [31:0] pts [10][3];
        pts = '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
                '{32'h0000_0000, 32'h0000_4000, 32'h0000_0000},
                '{32'h0000_0000, 32'h0000_8000, 32'h0000_0000},
                '{32'h0000_0800, 32'h0000_4000, 32'h0000_8000},
                '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                '{32'h0000_0001, 32'hFFFF_C000, 32'h0000_0001},
                '{32'h0000_F800, 32'h0000_3000, 32'h0001_7800},
                '{32'hFFFF_8000, 32'h0001_4000, 32'h7FFF_0000}};
        foreach (pts[i])
            send_point(pts[i][0], pts[i][1], pts[i][2]);
    endtask

    task automatic test_register_corners();
        program_registers('0, '0, '0, '0, '0, '0);
        send_point(32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        program_registers('1, '1, '1, '1, '1, '1);
        send_point(32'h0001_0000, 32'h0000_8000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        // mortar nearly as wide as the brick: the falling ramp starts almost at once
        program_registers(bpv_pkg::RST_INV_TOTAL_WIDTH, bpv_pkg::RST_INV_TOTAL_HEIGHT,
                          32'h0000_FFFF, 32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000);
        send_point(32'h0000_F000, 32'h0000_4000, 32'h0000_4000);
        send_point(32'h0000_F000, 32'h0000_7000, 32'h0000_F000);
        send_point(32'h0000_8000, 32'h0000_2000, 32'h0000_C000);
        program_reset_values();
        cfg_write(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        cfg_write(REG_UNMAPPED_HI, 32'h0000_0000);
        cfg_write(bpv_pkg::REG_MORTAR_FRAC_H, 32'hFFFF_1999);
        cfg_close();
        send_point(32'h0000_0400, 32'h0000_4000, 32'h0000_8000);
        send_point(32'h0000_8000, 32'h0000_0600, 32'h0000_8000);
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 8; s++)
        begin
            case (s)
                0: program_reset_values();
                1, 2: program_brick_layout(16'($urandom_range(1, 32768)),
                                           16'($urandom_range(1, 32768)));
                3: program_registers('0, '0, '0, '0, '0, '0);
                4: program_registers('1, '1, '1, '1, '1, '1);
                5: program_registers($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom);
                6: program_brick_layout(16'd32768, 16'd32768);
                default: program_brick_layout(16'd1, 16'd1);
            endcase
            send_random_points(150);
        end
    endtask

    task automatic test_steady_stream();
        program_brick_layout(16'($urandom_range(1, 32768)), 16'($urandom_range(1, 32768)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_points(300);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_hold();
        tx_idle_en = 1'b0;
        -> rx_hold_ev;
        send_random_points(150);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_sender_pause();
        for (int b = 0; b < 5; b++)
        begin
            send_random_points(20);
            drain_pipeline();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_extremes();
        test_register_corners();
        test_random_settings();
        test_steady_stream();
        test_output_hold();
        test_sender_pause();
        drain_pipeline();
        if (errors == 0 && pending_weights.size() == 0)
            $display("brick_pattern_value_unit: match");
        else
            $display("brick_pattern_value_unit: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("brick_pattern_value_unit: mismatch");
        $finish;
    end

endmodule
